// ===== sv/y2rgb_pkg.sv =====
// shared types and constants of the yuyv to rgb/bgr converter
// no dependencies; imported by every module of the block

package y2rgb_pkg;

   // default fraction bits of the fixed-point weights
   localparam int COEF_FRAC_BITS_DEF = 12;

   // configuration port geometry
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_ORDER = 2'd0;

   // channel order codes
   localparam logic ORDER_RGB = 1'b0;
   localparam logic ORDER_BGR = 1'b1;

   // one macropixel in
   typedef struct packed {
      logic [7:0] first_luma;
      logic [7:0] blue_diff;
      logic [7:0] second_luma;
      logic [7:0] red_diff;
      logic       frame_end_in;
   } req_type;

   // two pixels out
   typedef struct packed {
      logic [7:0] first_chan_zero;
      logic [7:0] first_chan_one;
      logic [7:0] first_chan_two;
      logic [7:0] second_chan_zero;
      logic [7:0] second_chan_one;
      logic [7:0] second_chan_two;
      logic       frame_end_out;
   } rsp_type;

   // three channels of one pixel
   typedef struct packed {
      logic [7:0] chan_zero;
      logic [7:0] chan_one;
      logic [7:0] chan_two;
   } pixel_type;

endpackage

// ===== sv/y2rgb_csr.sv =====
// configuration register file: channel order register behind an apb-style port
// depends on y2rgb_pkg

module y2rgb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [y2rgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [y2rgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [y2rgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic                             order
);
   import y2rgb_pkg::*;

   logic order_ff;
   logic order_in;
   logic wr_en;

   // write strobe on the access phase
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_ADDR_ORDER);

   // only bit 0 of the written data is kept
   always_comb begin
      order_in = order_ff;
      if (wr_en) begin
         order_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RGB;
      end else begin
         order_ff <= order_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_ORDER) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, order_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign order      = order_ff;

endmodule

// ===== sv/y2rgb_pixel.sv =====
// one pixel conversion: luma plus weighted chroma terms, floor and clamp
// depends on y2rgb_pkg

module y2rgb_pixel #(
   parameter int COEF_FRAC_BITS = y2rgb_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                  order,
   input  logic [7:0]            luma,
   input  logic signed [8:0]     du,
   input  logic signed [8:0]     dv,
   output y2rgb_pkg::pixel_type  pixel
);
   import y2rgb_pkg::*;

   // sums stay well inside f+11 signed bits
   localparam int SUM_W = COEF_FRAC_BITS + 11;

   // weights rounded to nearest at elaboration
   localparam logic signed [SUM_W-1:0] K1_CH0_V =
      SUM_W'(((64'd14075 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
   localparam logic signed [SUM_W-1:0] K1_CH1_U =
      SUM_W'(((64'd3455 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
   localparam logic signed [SUM_W-1:0] K1_CH1_V =
      SUM_W'(((64'd7169 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
   localparam logic signed [SUM_W-1:0] K1_CH2_U =
      SUM_W'(((64'd1779 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic signed [SUM_W-1:0] K2_CH0_U =
      SUM_W'(((64'd1732446 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
   localparam logic signed [SUM_W-1:0] K2_CH1_U =
      SUM_W'(((64'd337633 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
   localparam logic signed [SUM_W-1:0] K2_CH1_V =
      SUM_W'(((64'd698001 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
   localparam logic signed [SUM_W-1:0] K2_CH2_V =
      SUM_W'(((64'd1370705 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);

   logic signed [SUM_W-1:0] base;
   logic signed [SUM_W-1:0] du_x;
   logic signed [SUM_W-1:0] dv_x;
   logic signed [SUM_W-1:0] sum_zero;
   logic signed [SUM_W-1:0] sum_one;
   logic signed [SUM_W-1:0] sum_two;

   // floor to integer, then saturate to 0..255
   function automatic logic [7:0] clamp_q(input logic signed [SUM_W-1:0] sum);
      logic [7:0] res;
      if (sum[SUM_W-1]) begin
         res = 8'd0;
      end else if (|sum[SUM_W-2:COEF_FRAC_BITS+8]) begin
         res = 8'hFF;
      end else begin
         res = sum[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
      end
      return res;
   endfunction

   // operands aligned to the weight fraction
   assign base = $signed({3'b000, luma, {COEF_FRAC_BITS{1'b0}}});
   assign du_x = {{(SUM_W-9){du[8]}}, du};
   assign dv_x = {{(SUM_W-9){dv[8]}}, dv};

   // weighted sums for the selected weight set
   always_comb begin
      if (order == ORDER_BGR) begin
         sum_zero = base + K2_CH0_U * du_x;
         sum_one  = base - K2_CH1_U * du_x - K2_CH1_V * dv_x;
         sum_two  = base + K2_CH2_V * dv_x;
      end else begin
         sum_zero = base + K1_CH0_V * dv_x;
         sum_one  = base - K1_CH1_U * du_x - K1_CH1_V * dv_x;
         sum_two  = base + K1_CH2_U * du_x;
      end
   end

   assign pixel.chan_zero = clamp_q(sum_zero);
   assign pixel.chan_one  = clamp_q(sum_one);
   assign pixel.chan_two  = clamp_q(sum_two);

endmodule

// ===== sv/yuyv_to_rgb_or_bgr_unit.sv =====
// top level of the yuyv 4:2:2 to rgb888/bgr888 converter
// depends on y2rgb_pkg, y2rgb_csr and y2rgb_pixel

// Converts one YUYV macropixel into two 8-bit three-channel pixels (one
// weight set with red/green/blue order and another with blue/green/red order,
// chosen by the channel order register at byte address 0). One macropixel
// is taken every clock cycle while req_ready is high. A macropixel waits in
// the input register while the constant-weight multiplies and clamps run,
// then moves to the result register. Its pair is offered on the result port
// while it is in the result register and leaves at the first later edge at
// which rsp_ready is high. req_ready drops only while both registers are full
// and rsp_ready is low, and rises again in the same cycle as rsp_ready. Change
// the channel order only while no macropixel is in flight.

module yuyv_to_rgb_or_bgr_unit #(
   parameter int COEF_FRAC_BITS = y2rgb_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  y2rgb_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output y2rgb_pkg::rsp_type               rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [y2rgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [y2rgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [y2rgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import y2rgb_pkg::*;

   logic        order;
   logic        hold_valid_ff;
   logic        hold_valid_in;
   req_type     hold_ff;
   req_type     hold_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic        advance;
   logic        req_take;
   logic signed [8:0] du;
   logic signed [8:0] dv;
   pixel_type   pix_first;
   pixel_type   pix_second;

   // configuration registers
   y2rgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .order       (order)
   );

   // pipeline flow control
   assign advance   = hold_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !hold_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // input register
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (req_take) begin
         hold_valid_in = 1'b1;
         hold_in       = req_data;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   // chroma with the 128 offset removed, sign-extended to 9 bits
   assign du = {~hold_ff.blue_diff[7], ~hold_ff.blue_diff[7], hold_ff.blue_diff[6:0]};
   assign dv = {~hold_ff.red_diff[7], ~hold_ff.red_diff[7], hold_ff.red_diff[6:0]};

   // one converter per pixel of the pair
   y2rgb_pixel #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_pix_first (
      .order (order),
      .luma  (hold_ff.first_luma),
      .du    (du),
      .dv    (dv),
      .pixel (pix_first)
   );

   y2rgb_pixel #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_pix_second (
      .order (order),
      .luma  (hold_ff.second_luma),
      .du    (du),
      .dv    (dv),
      .pixel (pix_second)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in            = 1'b1;
         rsp_in.first_chan_zero  = pix_first.chan_zero;
         rsp_in.first_chan_one   = pix_first.chan_one;
         rsp_in.first_chan_two   = pix_first.chan_two;
         rsp_in.second_chan_zero = pix_second.chan_zero;
         rsp_in.second_chan_one  = pix_second.chan_one;
         rsp_in.second_chan_two  = pix_second.chan_two;
         rsp_in.frame_end_out    = hold_ff.frame_end_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a result only appears after a held macropixel moved on
   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(hold_valid_ff))
      else $error("result appeared without a held macropixel");

   // input only blocks when both registers are full and the output stalls
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (hold_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input blocked while pipeline has room");

   // last-of-frame mark follows its macropixel into the result register
   a_frame_end_kept: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.frame_end_out == $past(hold_ff.frame_end_in)))
      else $error("frame end mark lost between registers");
`endif

endmodule

// ===== bench/pixel_check_pkg.sv =====
// scoreboard of the yuyv to rgb/bgr converter testbench: predicts each pixel pair
// depends on y2rgb_pkg for the transfer types and the channel order codes

package pixel_check_pkg;

   import y2rgb_pkg::*;

   localparam int FRAC_BITS = COEF_FRAC_BITS_DEF;

   // weights rounded to nearest in fixed point, set one (red green blue)
   localparam longint RGB_V_TO_RED   = ((64'sd14075 << FRAC_BITS) + 5000) / 10000;
   localparam longint RGB_U_TO_GREEN = ((64'sd3455 << FRAC_BITS) + 5000) / 10000;
   localparam longint RGB_V_TO_GREEN = ((64'sd7169 << FRAC_BITS) + 5000) / 10000;
   localparam longint RGB_U_TO_BLUE  = ((64'sd1779 << FRAC_BITS) + 500) / 1000;

   // weights of set two (blue green red)
   localparam longint BGR_U_TO_BLUE  = ((64'sd1732446 << FRAC_BITS) + 500000) / 1000000;
   localparam longint BGR_U_TO_GREEN = ((64'sd337633 << FRAC_BITS) + 500000) / 1000000;
   localparam longint BGR_V_TO_GREEN = ((64'sd698001 << FRAC_BITS) + 500000) / 1000000;
   localparam longint BGR_V_TO_RED   = ((64'sd1370705 << FRAC_BITS) + 500000) / 1000000;

   class pixel_scoreboard;

      rsp_type expected_pairs[$];
      logic    channel_order;
      int      mismatches;

      function new();
         channel_order = ORDER_RGB;
         mismatches    = 0;
      endfunction

      function void set_order(logic order);
         channel_order = order;
      endfunction

      // floor to an integer, then clamp to a byte
      static function logic [7:0] saturate(longint sum);
         longint whole;
         if (sum < 0) begin
            return 8'd0;
         end
         whole = sum >>> FRAC_BITS;
         return (whole > 255) ? 8'd255 : whole[7:0];
      endfunction

      function pixel_type convert_pixel(logic [7:0] luma, longint du, longint dv);
         pixel_type px;
         longint    base;
         base = longint'(luma) << FRAC_BITS;
         if (channel_order == ORDER_RGB) begin
            px.chan_zero = saturate(base + RGB_V_TO_RED * dv);
            px.chan_one  = saturate(base - RGB_U_TO_GREEN * du - RGB_V_TO_GREEN * dv);
            px.chan_two  = saturate(base + RGB_U_TO_BLUE * du);
         end else begin
            px.chan_zero = saturate(base + BGR_U_TO_BLUE * du);
            px.chan_one  = saturate(base - BGR_U_TO_GREEN * du - BGR_V_TO_GREEN * dv);
            px.chan_two  = saturate(base + BGR_V_TO_RED * dv);
         end
         return px;
      endfunction

      // one accepted macropixel gives one expected pixel pair
      function void note_input(req_type item);
         rsp_type   pair;
         pixel_type px;
         longint    du;
         longint    dv;
         du = longint'(item.blue_diff) - 128;
         dv = longint'(item.red_diff) - 128;
         px = convert_pixel(item.first_luma, du, dv);
         pair.first_chan_zero = px.chan_zero;
         pair.first_chan_one  = px.chan_one;
         pair.first_chan_two  = px.chan_two;
         px = convert_pixel(item.second_luma, du, dv);
         pair.second_chan_zero = px.chan_zero;
         pair.second_chan_one  = px.chan_one;
         pair.second_chan_two  = px.chan_two;
         pair.frame_end_out    = item.frame_end_in;
         expected_pairs.push_back(pair);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch at %0t on %s: got %0d, want %0d", $time, what, got, want);
         mismatches++;
      endtask

      // compare a result transfer with the oldest expected pair
      task check_result(rsp_type got);
         rsp_type want;
         if (expected_pairs.size() == 0) begin
            report_mismatch("result with nothing pending", longint'(got), 0);
            return;
         end
         want = expected_pairs.pop_front();
         if (got.first_chan_zero !== want.first_chan_zero)
            report_mismatch("first_chan_zero", got.first_chan_zero, want.first_chan_zero);
         if (got.first_chan_one !== want.first_chan_one)
            report_mismatch("first_chan_one", got.first_chan_one, want.first_chan_one);
         if (got.first_chan_two !== want.first_chan_two)
            report_mismatch("first_chan_two", got.first_chan_two, want.first_chan_two);
         if (got.second_chan_zero !== want.second_chan_zero)
            report_mismatch("second_chan_zero", got.second_chan_zero, want.second_chan_zero);
         if (got.second_chan_one !== want.second_chan_one)
            report_mismatch("second_chan_one", got.second_chan_one, want.second_chan_one);
         if (got.second_chan_two !== want.second_chan_two)
            report_mismatch("second_chan_two", got.second_chan_two, want.second_chan_two);
         if (got.frame_end_out !== want.frame_end_out)
            report_mismatch("frame_end_out", got.frame_end_out, want.frame_end_out);
      endtask

   endclass

endpackage

// ===== bench/tb_top.sv =====
// top of the yuyv to rgb/bgr converter testbench: clock, reset, stimulus and checks
// depends on y2rgb_pkg, pixel_check_pkg and the yuyv_to_rgb_or_bgr_unit rtl

module tb_top;

   import y2rgb_pkg::*;
   import pixel_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PIPE_LATENCY   = 2;
   localparam int DIRECTED_COUNT = 12;
   localparam int BLOCK_ITEMS    = 119;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int send_idle_pct = 6;
   int recv_idle_pct = 86;
   int quiet_cycles  = 0;

   pixel_scoreboard sb = new();

   yuyv_to_rgb_or_bgr_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_input(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // one apb access, setup then access phase
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_order_readback();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, CSR_ADDR_ORDER, $urandom(), rd);
      if (rd[0] !== sb.channel_order) begin
         sb.report_mismatch("channel order readback", rd[0], sb.channel_order);
      end
   endtask

   // upper register bits get random values, only bit 0 counts
   task automatic set_channel_order(logic order);
      logic [CSR_DATA_W-1:0] wd;
      logic [CSR_DATA_W-1:0] rd;
      wd    = $urandom();
      wd[0] = order;
      csr_access(1'b1, CSR_ADDR_ORDER, wd, rd);
      sb.set_order(wd[0]);
      check_order_readback();
   endtask

   // offer one macropixel, with random idle cycles before it
   task automatic send_macropixel(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the input until every pending pair has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_pairs.size() != 0);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd128;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic req_type random_macropixel();
      req_type item;
      item.first_luma   = pick_byte();
      item.blue_diff    = pick_byte();
      item.second_luma  = pick_byte();
      item.red_diff     = pick_byte();
      item.frame_end_in = ($urandom_range(7) == 0);
      return item;
   endfunction

   // luma and chroma extremes, neutral chroma, saturation both ways
   function automatic req_type directed_macropixel(int idx);
      req_type item;
      case (idx)
         0:       item = {8'd0,   8'd0,   8'd0,   8'd0,   1'b0};
         1:       item = {8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
         2:       item = {8'd0,   8'd128, 8'd255, 8'd128, 1'b0};
         3:       item = {8'd255, 8'd0,   8'd0,   8'd255, 1'b1};
         4:       item = {8'd0,   8'd255, 8'd255, 8'd0,   1'b0};
         5:       item = {8'd128, 8'd128, 8'd128, 8'd128, 1'b1};
         6:       item = {8'd16,  8'd128, 8'd235, 8'd128, 1'b0};
         7:       item = {8'd0,   8'd255, 8'd0,   8'd255, 1'b0};
         8:       item = {8'd255, 8'd0,   8'd255, 8'd0,   1'b1};
         9:       item = {8'd127, 8'd127, 8'd129, 8'd129, 1'b0};
         10:      item = {8'd1,   8'd129, 8'd254, 8'd127, 1'b1};
         default: item = {8'd200, 8'd50,  8'd60,  8'd210, 1'b0};
      endcase
      return item;
   endfunction

   // stimulus
   initial begin
      int pause_at;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_ready   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pairs, reset order first, then the other set
      check_order_readback();
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_macropixel(directed_macropixel(i));
      end
      wait_drained();
      set_channel_order(ORDER_BGR);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_macropixel(directed_macropixel(i));
      end
      wait_drained();

      // random blocks, three idle profiles, both orders in each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int blk = 0; blk < 4; blk++) begin
            set_channel_order(blk[0] ? ORDER_RGB : ORDER_BGR);
            pause_at = $urandom_range(20, BLOCK_ITEMS - 20);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
               if (n == pause_at) begin
                  wait_drained();
               end
               send_macropixel(random_macropixel());
            end
            wait_drained();
         end
      end

      repeat (PIPE_LATENCY + 2) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_pairs.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/y2rgb_pkg.sv
sv/y2rgb_csr.sv
sv/y2rgb_pixel.sv
sv/yuyv_to_rgb_or_bgr_unit.sv
bench/pixel_check_pkg.sv
bench/tb_top.sv
